// File: sv/llhp_pkg.sv
package llhp_pkg;

	localparam int SAMPLE_W = 32;
	localparam int PCT_W = 17;
	localparam int TOTAL_W = 40;
	localparam int BIN_W = 10;
	localparam int COUNT_W = 32;
	localparam int LOGMIN_W = 22;
	localparam int SCALE_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 22;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_LOG2 = 1'd1;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd32;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_RECORD = 2'd0,
		ACT_INTERVAL = 2'd1,
		ACT_CUMULATIVE = 2'd2,
		ACT_CHECKPOINT = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		logic [SAMPLE_W-1:0] sample_value;
		logic [PCT_W-1:0] percentile_q16;
		logic end_of_batch;
	} in_word_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic [TOTAL_W-1:0] total_events;
	} out_word_t;

endpackage

// File: sv/llhp_binmap.sv
module llhp_binmap import llhp_pkg::*; (
	input  logic clk,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic signed [LOGMIN_W-1:0] log_min,
	input  logic [SCALE_W-1:0] scale,
	output logic [BIN_W-1:0] bin
);
	localparam int BIN_AW = BIN_W;

	logic [4:0] lead;
	logic [15:0] frac;
	logic [SAMPLE_W-1:0] norm;
	logic signed [23:0] diff;
	logic signed [23:0] diff_s1;
	logic zero_s1;
	logic signed [41:0] prod;
	logic signed [41:0] idx;

	always_comb begin
		lead = '0;
		for (int i = 0; i < SAMPLE_W; i++) begin
			if (sample[i]) begin
				lead = 5'(i);
			end
		end
		norm = sample << (5'd31 - lead);
		frac = norm[30:15];
		diff = $signed({2'b00, lead, frac}) - 24'(log_min);
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff;
		zero_s1 <= (sample == '0);
	end

	always_comb begin
		prod = 42'(diff_s1) * $signed({1'b0, scale}) + 42'sd8388608;
		idx = prod >>> 24;
		if (zero_s1 || prod < 0) begin
			bin = '0;
		end else if (idx >= 42'(2 ** BIN_AW - 1)) begin
			bin = '1;
		end else begin
			bin = idx[BIN_AW-1:0];
		end
	end
endmodule

// File: sv/llhp_seq.sv
module llhp_seq import llhp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  in_word_t word,
	input  logic [BIN_W-1:0] rec_bin,
	output logic busy,
	output logic done,
	output out_word_t result
);
	localparam int BIN_AW = BIN_W;
	localparam int BINS = 2 ** BIN_AW;

	typedef enum logic [3:0] {
		S_IDLE, S_REC_MAP, S_REC_RD, S_REC_WR, S_WALK, S_FOLD, S_CLR, S_TGT, S_INIT
	} state_t;

	logic [COUNT_W-1:0] imem [BINS];
	logic [COUNT_W-1:0] cmem [BINS];
	logic [COUNT_W-1:0] irdata_q, crdata_q;

	state_t state_q;
	in_word_t word_q;
	logic [BIN_AW-1:0] addr_q;
	logic [BIN_AW:0] rd_cnt_q;
	logic [BIN_AW-1:0] wb_addr_q;
	logic wb_vld_q;
	logic [TOTAL_W-1:0] itot_q, ctot_q;
	logic [TOTAL_W-1:0] tot_q, target_q, run_q;
	logic found_q;
	logic [BIN_AW-1:0] hit_q;
	logic fold_walk_q;
	logic [TOTAL_W+PCT_W:0] tprod;
	logic [PCT_W-1:0] pcl;
	logic [COUNT_W:0] fsum;
	logic [TOTAL_W:0] tsum;
	logic [TOTAL_W:0] rsum;
	logic [COUNT_W-1:0] walk_data;

	assign busy = (state_q != S_IDLE);
	assign pcl = (word_q.percentile_q16 > PCT_W'(65536)) ? PCT_W'(65536)
		: word_q.percentile_q16;
	assign tprod = (TOTAL_W+PCT_W+1)'(tot_q) * (TOTAL_W+PCT_W+1)'(pcl)
		+ (TOTAL_W+PCT_W+1)'(32768);
	assign fsum = {1'b0, crdata_q} + {1'b0, irdata_q};
	assign tsum = {1'b0, ctot_q} + {1'b0, itot_q};
	assign walk_data = (word_q.action == ACT_INTERVAL) ? irdata_q : crdata_q;
	assign rsum = {1'b0, run_q} + (TOTAL_W+1)'(walk_data);

	always_ff @(posedge clk) begin
		irdata_q <= imem[addr_q];
		crdata_q <= cmem[addr_q];
		if (state_q == S_REC_WR && irdata_q != COUNT_MAX) begin
			imem[addr_q] <= irdata_q + COUNT_W'(1);
		end
		if (state_q == S_FOLD && wb_vld_q) begin
			cmem[wb_addr_q] <= fsum[COUNT_W] ? COUNT_MAX : fsum[COUNT_W-1:0];
			imem[wb_addr_q] <= '0;
		end
		if (state_q == S_CLR) begin
			cmem[addr_q] <= '0;
		end
		if (state_q == S_INIT) begin
			imem[addr_q] <= '0;
			cmem[addr_q] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			itot_q <= '0;
			ctot_q <= '0;
			done <= 1'b0;
			addr_q <= '0;
			rd_cnt_q <= '0;
			wb_vld_q <= 1'b0;
			found_q <= 1'b0;
			fold_walk_q <= 1'b0;
			word_q <= '0;
			tot_q <= '0;
			target_q <= '0;
			run_q <= '0;
			hit_q <= '0;
			wb_addr_q <= '0;
			result <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						word_q <= word;
						addr_q <= '0;
						rd_cnt_q <= '0;
						wb_vld_q <= 1'b0;
						if (word.action == ACT_RECORD) begin
							state_q <= S_REC_MAP;
						end else if (word.action == ACT_INTERVAL) begin
							tot_q <= itot_q;
							fold_walk_q <= 1'b0;
							state_q <= S_TGT;
						end else begin
							fold_walk_q <= 1'b1;
							state_q <= S_FOLD;
						end
					end
				end
				S_REC_MAP: begin
					addr_q <= rec_bin;
					state_q <= S_REC_RD;
				end
				S_REC_RD: state_q <= S_REC_WR;
				S_REC_WR: begin
					if (irdata_q != COUNT_MAX && itot_q != TOTAL_MAX) begin
						itot_q <= itot_q + TOTAL_W'(1);
					end
					state_q <= S_IDLE;
				end
				S_FOLD: begin
					wb_vld_q <= (rd_cnt_q < (BIN_AW+1)'(BINS));
					wb_addr_q <= addr_q;
					if (rd_cnt_q < (BIN_AW+1)'(BINS)) begin
						addr_q <= addr_q + BIN_AW'(1);
						rd_cnt_q <= rd_cnt_q + (BIN_AW+1)'(1);
					end else if (!wb_vld_q) begin
						ctot_q <= tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
						itot_q <= '0;
						addr_q <= '0;
						rd_cnt_q <= '0;
						if (fold_walk_q) begin
							tot_q <= tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
							state_q <= S_TGT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_TGT: begin
					target_q <= tprod[TOTAL_W+16-1:16];
					run_q <= '0;
					found_q <= 1'b0;
					hit_q <= '1;
					addr_q <= '0;
					rd_cnt_q <= '0;
					wb_vld_q <= 1'b0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					wb_vld_q <= (rd_cnt_q < (BIN_AW+1)'(BINS));
					wb_addr_q <= addr_q;
					if (rd_cnt_q < (BIN_AW+1)'(BINS)) begin
						addr_q <= addr_q + BIN_AW'(1);
						rd_cnt_q <= rd_cnt_q + (BIN_AW+1)'(1);
					end
					if (wb_vld_q && !found_q) begin
						run_q <= rsum[TOTAL_W] ? TOTAL_MAX : rsum[TOTAL_W-1:0];
						if (rsum >= {1'b0, target_q}) begin
							found_q <= 1'b1;
							hit_q <= wb_addr_q;
						end
					end
					if (!wb_vld_q && rd_cnt_q == (BIN_AW+1)'(BINS)) begin
						result.bin_index <= BIN_W'(hit_q);
						result.total_events <= tot_q;
						done <= 1'b1;
						addr_q <= '0;
						rd_cnt_q <= '0;
						fold_walk_q <= 1'b0;
						if (word_q.action == ACT_CHECKPOINT) begin
							ctot_q <= '0;
							state_q <= S_CLR;
						end else if (word_q.action == ACT_INTERVAL
							&& word_q.end_of_batch) begin
							state_q <= S_FOLD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CLR: begin
					addr_q <= addr_q + BIN_AW'(1);
					if (addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					addr_q <= addr_q + BIN_AW'(1);
					if (addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/log_latency_histogram_percentile_core.sv
// Log-scale latency histogram. A record passes through a log map, a memory
// read and a write back; busy is high meanwhile. A query walks all BINS
// entries of one memory; cumulative and checkpoint queries first fold the
// interval memory into the cumulative one, an end-of-batch interval query
// folds afterwards, and a checkpoint clears the cumulative memory afterwards.
// After reset both memories are cleared, and busy stays high while they are.
// The answer shows for one cycle with done high and must be taken then: the
// receiver cannot stall it. Start is taken only while busy is low.
module log_latency_histogram_percentile_core import llhp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_word_t in_word,
	output logic done,
	output out_word_t out_word,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic signed [LOGMIN_W-1:0] log_min_q;
	logic [SCALE_W-1:0] scale_q;
	logic [BIN_W-1:0] rec_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_min_q <= '0;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOG_MIN: log_min_q <= cfg_data[LOGMIN_W-1:0];
				CFG_BINS_PER_LOG2: scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	llhp_binmap u_map (
		.clk(clk),
		.sample(in_word.sample_value),
		.log_min(log_min_q),
		.scale(scale_q),
		.bin(rec_bin)
	);

	llhp_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.take(start && !busy),
		.word(in_word),
		.rec_bin(rec_bin),
		.busy(busy),
		.done(done),
		.result(out_word)
	);
endmodule

// File: sv/llhp_checker.sv
module llhp_checker import llhp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_word_t in_word,
	input  logic done
);
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_rec_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_word.action == ACT_RECORD |=> !done ##1 !done)
		else $error("record produced a result");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result while idle");
endmodule

bind log_latency_histogram_percentile_core llhp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.in_word(in_word), .done(done)
);
